// File: rtl/core/wmpm_pkg.sv
// Shared widths, register indexes and control structs of the peak meter.
package wmpm_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CH_W       = 4;
    localparam int NCH_W      = 5;
    localparam int CNT_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int CH_LIMIT   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    localparam logic [NCH_W-1:0]    RST_ACTIVE = 5'd1;
    localparam logic [SAMPLE_W-1:0] RST_WINDOW = 24'd4096;

    // report request from the fold stage to the sequencer
    typedef struct packed {
        logic             vld;
        logic [NCH_W-1:0] nch;
    } t_rpt_start;

    // read request from the sequencer to the peak memory
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rpt_stat;

endpackage

// File: rtl/core/windowed_multichannel_peak_meter.sv
// Top level: configuration, peak fold read-modify-write, window counter, report.
// A triggering block end passes the fold stage register and the S_REQ and S_WAIT
// states before its first result is registered at the output. Throughput: one sample
// per cycle; input stalls after an enabled block end until its report decision, and
// while a report reads each active peak. Reset: registers take their defaults;
// per-channel valid bits make all peaks read as zero at once; no clearing pass.
module windowed_multichannel_peak_meter #(
    parameter int MAX_CHANS = 16,
    parameter int BLOCK_LEN = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wmpm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wmpm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wmpm_pkg::SAMPLE_W-1:0]        s_tdata,  // [23:0] sample
    input  logic [wmpm_pkg::CH_W-1:0]            s_tuser,  // [3:0] channel
    input  logic                                 s_tlast,  // block_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wmpm_pkg::SAMPLE_W-1:0]        m_tdata,  // [23:0] peak
    output logic [wmpm_pkg::CH_W-1:0]            m_tuser,  // [3:0] peak_channel
    output logic                                 m_tlast   // last
);

    localparam int NUM_CH = (MAX_CHANS < wmpm_pkg::CH_LIMIT) ? MAX_CHANS : wmpm_pkg::CH_LIMIT;
    localparam int AW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int SUM_W  = wmpm_pkg::CNT_W + 1;
    localparam logic [SUM_W-1:0] BLK_INC = SUM_W'(BLOCK_LEN);
    localparam logic [SUM_W-1:0] CNT_SAT = {1'b0, {wmpm_pkg::CNT_W{1'b1}}};
    localparam logic [wmpm_pkg::NCH_W-1:0] NCH_MAX = wmpm_pkg::NCH_W'(NUM_CH);

    // configuration
    logic                              r_enable;
    logic [wmpm_pkg::NCH_W-1:0]        r_active;
    logic [wmpm_pkg::SAMPLE_W-1:0]     r_window;
    logic [wmpm_pkg::NCH_W-1:0]        nch;

    // fold stage
    logic                              s_acc;
    logic                              r_s1_vld;
    logic [wmpm_pkg::SAMPLE_W-1:0]     r_s1_sample;
    logic [wmpm_pkg::CH_W-1:0]         r_s1_ch;
    logic                              r_s1_last;
    logic                              r_rd_vld;
    logic                              r_fw_vld;
    logic [wmpm_pkg::CH_W-1:0]         r_fw_ch;
    logic [wmpm_pkg::SAMPLE_W-1:0]     r_fw_val;
    logic [NUM_CH-1:0]                 r_valid;
    logic [wmpm_pkg::CNT_W-1:0]        r_count;

    logic [wmpm_pkg::SAMPLE_W-1:0]     ram_q;
    logic [wmpm_pkg::SAMPLE_W-1:0]     rd_masked;
    logic [wmpm_pkg::SAMPLE_W-1:0]     mag;
    logic [wmpm_pkg::SAMPLE_W-1:0]     old_peak;
    logic [wmpm_pkg::SAMPLE_W-1:0]     new_peak;
    logic                              wr_en;
    logic                              blk_end;
    logic [SUM_W-1:0]                  cnt_sum;
    logic [wmpm_pkg::CNT_W-1:0]        cnt_next;
    logic                              trigger;

    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [AW-1:0]                     ram_waddr;
    logic                              raddr_ok;
    logic [wmpm_pkg::CH_W-1:0]         rd_ch;

    wmpm_pkg::t_rpt_start              rpt_start;
    wmpm_pkg::t_rd_req                 rpt_rd;
    wmpm_pkg::t_rpt_stat               rpt_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_active <= wmpm_pkg::RST_ACTIVE;
            r_window <= wmpm_pkg::RST_WINDOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wmpm_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                wmpm_pkg::CFG_ACTIVE: r_active <= i_cfg_data[wmpm_pkg::NCH_W-1:0];
                wmpm_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp the channel count to 1 .. NUM_CH
    always_comb begin
        if (r_active == '0) begin
            nch = wmpm_pkg::NCH_W'(1);
        end else if (r_active > NCH_MAX) begin
            nch = NCH_MAX;
        end else begin
            nch = r_active;
        end
    end

    // stall behind a block end until its report decision is made, and during a report
    assign s_tready = !rpt_stat.busy && !(r_s1_vld && r_s1_last);
    assign s_acc    = s_tvalid && s_tready;

    // peak memory read port: input samples, or the sequencer during a report
    assign ram_re    = s_acc || rpt_rd.en;
    assign rd_ch     = rpt_rd.en ? rpt_rd.addr : s_tuser;
    assign ram_raddr = rd_ch[AW-1:0];
    assign raddr_ok  = {1'b0, rd_ch} < NCH_MAX;
    assign ram_waddr = r_s1_ch[AW-1:0];

    wmpm_ram #(
        .WIDTH (wmpm_pkg::SAMPLE_W),
        .DEPTH (NUM_CH)
    ) u_peaks (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ram_waddr),
        .i_wdata (new_peak),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // an entry not written since the last clear reads as zero
    assign rd_masked = r_rd_vld ? ram_q : '0;

    assign mag = r_s1_sample[wmpm_pkg::SAMPLE_W-1] ? (~r_s1_sample + wmpm_pkg::SAMPLE_W'(1))
                                                   : r_s1_sample;

    // forward the previous write when the same channel follows at once
    assign old_peak = (r_fw_vld && (r_fw_ch == r_s1_ch)) ? r_fw_val : rd_masked;
    assign new_peak = (mag > old_peak) ? mag : old_peak;
    assign wr_en    = r_s1_vld && ({1'b0, r_s1_ch} < nch);

    assign blk_end  = r_s1_vld && r_s1_last;
    assign cnt_sum  = {1'b0, r_count} + BLK_INC;
    assign cnt_next = (cnt_sum > CNT_SAT) ? CNT_SAT[wmpm_pkg::CNT_W-1:0]
                                          : cnt_sum[wmpm_pkg::CNT_W-1:0];
    assign trigger  = blk_end && (cnt_next >= {1'b0, r_window});

    assign rpt_start.vld = trigger;
    assign rpt_start.nch = nch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_valid  <= '0;
            r_count  <= '0;
        end else begin
            r_s1_vld <= s_acc && r_enable;
            r_fw_vld <= wr_en;
            if (rpt_stat.done) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (blk_end) begin
                r_count <= trigger ? '0 : cnt_next;
            end
        end
        if (s_acc) begin
            r_s1_sample <= s_tdata;
            r_s1_ch     <= s_tuser;
            r_s1_last   <= s_tlast;
        end
        if (ram_re) begin
            r_rd_vld <= raddr_ok && r_valid[ram_raddr];
        end
        r_fw_ch  <= r_s1_ch;
        r_fw_val <= new_peak;
    end

    wmpm_report u_report (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (rpt_start),
        .i_rdata  (rd_masked),
        .o_rd     (rpt_rd),
        .o_stat   (rpt_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/core/wmpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wmpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/core/wmpm_report.sv
// Report sequencer: reads each active channel's peak and drives the result stream.
module wmpm_report (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wmpm_pkg::t_rpt_start             i_start,
    input  logic [wmpm_pkg::SAMPLE_W-1:0]    i_rdata,
    output wmpm_pkg::t_rd_req                o_rd,
    output wmpm_pkg::t_rpt_stat              o_stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wmpm_pkg::SAMPLE_W-1:0]    m_tdata,  // [23:0] peak
    output logic [wmpm_pkg::CH_W-1:0]        m_tuser,  // [3:0] peak_channel
    output logic                             m_tlast
);

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_REQ  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                         r_state, n_state;
    logic [wmpm_pkg::CH_W-1:0]      r_idx, n_idx;
    logic [wmpm_pkg::NCH_W-1:0]     r_nch, n_nch;
    logic                           r_valid, n_valid;
    logic [wmpm_pkg::SAMPLE_W-1:0]  r_peak, n_peak;
    logic [wmpm_pkg::CH_W-1:0]      r_ch, n_ch;
    logic                           r_last, n_last;
    logic                           is_last;
    logic                           done;

    assign is_last = ({1'b0, r_idx} + wmpm_pkg::NCH_W'(1)) == r_nch;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_nch   = r_nch;
        n_valid = r_valid;
        n_peak  = r_peak;
        n_ch    = r_ch;
        n_last  = r_last;
        done    = 1'b0;
        if (r_valid && m_tready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_RUN: begin
                if (i_start.vld) begin
                    n_state = S_REQ;
                    n_idx   = '0;
                    n_nch   = i_start.nch;
                end
            end
            S_REQ: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // hold the read data until the output register is free
                if (!r_valid || m_tready) begin
                    n_valid = 1'b1;
                    n_peak  = i_rdata;
                    n_ch    = r_idx;
                    n_last  = is_last;
                    if (is_last) begin
                        n_state = S_RUN;
                        done    = 1'b1;
                    end else begin
                        n_state = S_REQ;
                        n_idx   = r_idx + wmpm_pkg::CH_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_idx  <= n_idx;
        r_nch  <= n_nch;
        r_peak <= n_peak;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    assign o_rd.en     = (r_state == S_REQ);
    assign o_rd.addr   = r_idx;
    assign o_stat.busy = (r_state != S_RUN);
    assign o_stat.done = done;

    assign m_tvalid = r_valid;
    assign m_tdata  = r_peak;
    assign m_tuser  = r_ch;
    assign m_tlast  = r_last;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the windowed multichannel peak meter.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_CHANS = 16;
    localparam int BLOCK_LEN = 32;

    localparam int SAMPLE_W   = wmpm_pkg::SAMPLE_W;
    localparam int CH_W       = wmpm_pkg::CH_W;
    localparam int NCH_W      = wmpm_pkg::NCH_W;
    localparam int CNT_W      = wmpm_pkg::CNT_W;
    localparam int CFG_IDX_W  = wmpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = wmpm_pkg::CFG_DATA_W;
    localparam int CH_LIMIT   = wmpm_pkg::CH_LIMIT;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = wmpm_pkg::CFG_ENABLE;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = wmpm_pkg::CFG_ACTIVE;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = wmpm_pkg::CFG_WINDOW;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_op;

    typedef struct packed {
        t_row_op                op;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SAMPLE_W-1:0]    val;
        logic [CH_W-1:0]        ch;
        logic                   blk;
        logic [1:0]             n_typed;
        logic [SAMPLE_W-1:0]    t0;
        logic [SAMPLE_W-1:0]    t1;
    } t_dir_row;

    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [CH_W-1:0]     chan;
        logic                last;
    } t_peak_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;   // [23:0] sample
    logic [CH_W-1:0]       s_tuser = '0;   // [3:0] channel
    logic                  s_tlast = 1'b0; // block_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;        // [23:0] peak
    logic [CH_W-1:0]       m_tuser;        // [3:0] peak_channel
    logic                  m_tlast;        // last

    windowed_multichannel_peak_meter #(
        .MAX_CHANS(MAX_CHANS),
        .BLOCK_LEN(BLOCK_LEN)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Shadow of the meter: registers, per-channel peaks and window counter
    logic                cfg_enable = 1'b0;
    logic [NCH_W-1:0]    cfg_active = wmpm_pkg::RST_ACTIVE;
    logic [SAMPLE_W-1:0] cfg_window = wmpm_pkg::RST_WINDOW;
    logic [SAMPLE_W-1:0] peak_mem [MAX_CHANS];
    logic [CNT_W-1:0]    win_count = '0;

    t_peak_res peaks_due [$];
    t_peak_res got_want;

    int mismatches = 0;
    int live_items = 0;
    int dead_items = 0;
    int results_due = 0;
    int results_seen = 0;
    int reports = 0;

    logic tx_gappy = 1'b0;
    int   tx_burst = 0;
    logic rx_calm = 1'b1;
    logic rx_hold = 1'b0;
    int   rx_run = 0;

    // Directed rows: typed expectations where the peaks are obvious, predictor elsewhere.
    // Index field is unused on sample rows.
    t_dir_row dir_rows [32] = '{
        '{ROW_ITEM, '0,         24'h7FFFFF, 4'd0,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_ENABLE, 24'h000001, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h800000, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h7FFFFF, 4'd3,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h000000, 4'd3,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_WINDOW, 24'd32,     4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'hFFFFFF, 4'd0,  1'b1, 2'd1, 24'h800000, 24'h000000},
        '{ROW_CFG,  CFG_ACTIVE, 24'd2,      4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h7FFFFF, 4'd1,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h000001, 4'd0,  1'b1, 2'd2, 24'h000001, 24'h7FFFFF},
        '{ROW_ITEM, '0,         24'h000000, 4'd1,  1'b1, 2'd2, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_WINDOW, 24'd0,      4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h800001, 4'd0,  1'b1, 2'd2, 24'h7FFFFF, 24'h000000},
        '{ROW_CFG,  CFG_ACTIVE, 24'd0,      4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h000100, 4'd1,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'hFFFFFB, 4'd0,  1'b1, 2'd1, 24'h000005, 24'h000000},
        '{ROW_CFG,  CFG_SPARE,  24'hABCDEF, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_ACTIVE, 24'd31,     4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h800000, 4'd15, 1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h123456, 4'd7,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_ACTIVE, 24'd16,     4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_WINDOW, 24'hFFFFFF, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h000005, 4'd15, 1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'hFFFFF9, 4'd2,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_WINDOW, 24'd64,     4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h000003, 4'd2,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_WINDOW, 24'd33,     4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h7FFFFF, 4'd4,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'hFFFFFD, 4'd4,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_ENABLE, 24'h000000, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000},
        '{ROW_ITEM, '0,         24'h800000, 4'd0,  1'b1, 2'd0, 24'h000000, 24'h000000},
        '{ROW_CFG,  CFG_ENABLE, 24'h000001, 4'd0,  1'b0, 2'd0, 24'h000000, 24'h000000}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("windowed_multichannel_peak_meter test failed");
        $finish;
    end

    // Clamp the channel register to 1 .. 16
    function automatic int eff_chans();
        if (cfg_active == '0)
            return 1;
        if (cfg_active > CH_LIMIT)
            return CH_LIMIT;
        return int'(cfg_active);
    endfunction

    function automatic int meter_step(input logic [SAMPLE_W-1:0] smp,
                                      input logic [CH_W-1:0] ch, input logic blk,
                                      output t_peak_res res [MAX_CHANS]);
        int                  nch;
        logic [SAMPLE_W-1:0] mag;
        logic [CNT_W:0]      sum;
        if (!cfg_enable)
            return 0;
        nch = eff_chans();
        if (int'(ch) < nch) begin
            mag = smp[SAMPLE_W-1] ? (~smp) + 1'b1 : smp;
            if (mag > peak_mem[ch])
                peak_mem[ch] = mag;
        end
        if (!blk)
            return 0;
        sum = {1'b0, win_count} + (CNT_W+1)'(BLOCK_LEN);
        win_count = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
        if (win_count < {1'b0, cfg_window})
            return 0;
        for (int i = 0; i < nch; i++) begin
            res[i].peak = peak_mem[i];
            res[i].chan = CH_W'(i);
            res[i].last = (i == nch - 1);
        end
        foreach (peak_mem[i])
            peak_mem[i] = '0;
        win_count = '0;
        return nch;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Drop valid and hold until every expected peak has left the meter
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (peaks_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: cfg_enable = val[0];
            CFG_ACTIVE: cfg_active = val[NCH_W-1:0];
            CFG_WINDOW: cfg_window = val[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [CH_W-1:0] ch,
                               input logic blk, input logic [1:0] n_typed,
                               input logic [SAMPLE_W-1:0] t0, input logic [SAMPLE_W-1:0] t1);
        t_peak_res res [MAX_CHANS];
        int        n;
        if (tx_gappy && tx_burst == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            tx_burst = $urandom_range(1, 12);
        end
        if (tx_burst > 0)
            tx_burst--;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        s_tlast  <= blk;
        do @(posedge i_clk); while (!s_tready);
        if (cfg_enable)
            live_items++;
        else
            dead_items++;
        n = meter_step(smp, ch, blk, res);
        if (n_typed != 0) begin
            n = int'(n_typed);
            for (int i = 0; i < n; i++) begin
                res[i].peak = (i == 0) ? t0 : t1;
                res[i].chan = CH_W'(i);
                res[i].last = (i == n - 1);
            end
        end
        for (int i = 0; i < n; i++)
            peaks_due.push_back(res[i]);
        if (n > 0)
            reports++;
        results_due += n;
    endtask

    // Receiver: alternate ready and stall stretches unless told to stay calm
    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            rx_hold = !rx_hold;
            rx_run = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end else begin
            rx_run--;
        end
        m_tready <= rx_calm || !rx_hold;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (peaks_due.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer: peak %h ch %0d last %b",
                                        m_tdata, m_tuser, m_tlast));
            end else begin
                got_want = peaks_due.pop_front();
                if (m_tdata !== got_want.peak || m_tuser !== got_want.chan ||
                    m_tlast !== got_want.last)
                    note_mismatch($sformatf(
                        "peak %h ch %0d last %b, expected peak %h ch %0d last %b",
                        m_tdata, m_tuser, m_tlast,
                        got_want.peak, got_want.chan, got_want.last));
            end
        end
    end

    initial begin
        int                  ph;
        int                  n_ph;
        int                  nch;
        int                  pos;
        int                  blk_size;
        logic                want_en;
        logic [CFG_DATA_W-1:0] act_val;
        logic [CFG_DATA_W-1:0] win_val;
        logic [CH_W-1:0]     ch;
        logic                blk;
        logic [SAMPLE_W-1:0] smp;

        foreach (peak_mem[i])
            peak_mem[i] = '0;
        ph = 0;
        pos = 0;
        blk_size = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_CFG)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_sample(dir_rows[r].val, dir_rows[r].ch, dir_rows[r].blk,
                            dir_rows[r].n_typed, dir_rows[r].t0, dir_rows[r].t1);
        end

        while (live_items + dead_items < 360) begin
            case ($urandom_range(0, 9))
                0:       act_val = CFG_DATA_W'(1);
                1:       act_val = CFG_DATA_W'(CH_LIMIT);
                2:       act_val = CFG_DATA_W'($urandom_range(0, 31));
                default: act_val = CFG_DATA_W'($urandom_range(1, CH_LIMIT));
            endcase
            case ($urandom_range(0, 11))
                0:       win_val = '0;
                1:       win_val = {CFG_DATA_W{1'b1}};
                2:       win_val = CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
                3, 4:    win_val = CFG_DATA_W'(BLOCK_LEN);
                default: win_val = CFG_DATA_W'($urandom_range(1, 5 * BLOCK_LEN));
            endcase
            write_reg(CFG_ACTIVE, act_val);
            write_reg(CFG_WINDOW, win_val);
            want_en = (ph % 6 != 4);
            if (want_en != cfg_enable)
                write_reg(CFG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, want_en});
            tx_gappy = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_calm = (ph == 0) || ($urandom_range(0, 4) == 0);
            n_ph = $urandom_range(15, 45);
            nch = eff_chans();
            pos = 0;
            for (int i = 0; i < n_ph; i++) begin
                // hold the sender once until the meter has emptied
                if (ph == 3 && i == n_ph / 2)
                    drain();
                // well-formed block: channels in turn, block end on the last sample
                if (pos == 0)
                    blk_size = nch * int'($urandom_range(1, 2));
                ch = CH_W'(pos % nch);
                blk = (pos == blk_size - 1);
                pos = blk ? 0 : pos + 1;
                if ($urandom_range(0, 6) == 0) begin
                    ch = CH_W'($urandom_range(0, 15));
                    blk = ($urandom_range(0, 3) == 0);
                end
                case ($urandom_range(0, 9))
                    0:       smp = 24'h800000;
                    1:       smp = 24'h7FFFFF;
                    2:       smp = SAMPLE_W'($urandom_range(0, 255));
                    3:       smp = 24'hFFFFFF - SAMPLE_W'($urandom_range(0, 255));
                    default: smp = SAMPLE_W'($urandom);
                endcase
                send_sample(smp, ch, blk, 2'd0, '0, '0);
            end
            ph++;
        end

        s_tvalid <= 1'b0;
        while (peaks_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d samples (%0d while disabled) over %0d settings; %0d reports.",
                 live_items + dead_items, dead_items, ph, reports);
        $display("Checked %0d of %0d peak results, %0d mismatches.",
                 results_seen, results_due, mismatches);
        if (mismatches == 0 && peaks_due.size() == 0)
            $display("windowed_multichannel_peak_meter test passed");
        else
            $display("windowed_multichannel_peak_meter test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/wmpm_pkg.sv
rtl/core/wmpm_ram.sv
rtl/core/wmpm_report.sv
rtl/core/windowed_multichannel_peak_meter.sv
verif/tb_top.sv
